@@ hw/rtl/pcpe_pkg.sv @@
// pcpe_pkg: widths, codes, row and result types and saturation helpers
// for the piecewise cubic profile evaluator; depends on nothing
package pcpe_pkg;

  localparam int VAL_W         = 48;
  localparam int IDX_W         = 6;
  localparam int CFG_W         = 7;
  localparam int STAT_W        = 2;
  localparam int OP_W          = VAL_W + 1;
  localparam int HALF_W        = (OP_W + 1) / 2;
  localparam int PROD_W        = 4 * HALF_W;
  localparam int ROW_W         = 6 * VAL_W;
  localparam int MAX_NODES_DEF = 64;
  localparam int FRAC_BITS_DEF = 32;
  localparam int CFG_RESET     = 2;

  // binary32 mantissa of one sixth, weight 2^-26
  localparam logic [23:0] SIXTH_MANT = 24'd11184811;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HINT  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SPEED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LOAD  = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] depth;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] slope;
    logic signed [VAL_W-1:0] bend;
    logic signed [VAL_W-1:0] third;
    logic signed [VAL_W-1:0] density;
  } row_t;

  typedef struct packed {
    logic                    ov;
    logic signed [VAL_W-1:0] v;
  } sat_t;

  typedef struct packed {
    logic                    done;
    logic                    neg;
    logic                    ov;
    logic signed [VAL_W-1:0] q;
    logic [PROD_W-1:0]       mag;
  } mul_res_t;

  // clamp a 49-bit sum into the 48-bit range
  function automatic sat_t sat_fit(input logic signed [VAL_W:0] s);
    sat_t r;
    if (s[VAL_W] != s[VAL_W-1]) begin
      r.ov = 1'b1;
      r.v  = s[VAL_W] ? VMIN : VMAX;
    end else begin
      r.ov = 1'b0;
      r.v  = s[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sat_add(input logic signed [VAL_W-1:0] a,
                                   input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    return sat_fit(s);
  endfunction

  // signed value from magnitude and sign, saturated
  function automatic sat_t sat_mag(input logic [PROD_W-1:0] m, input logic neg);
    sat_t r;
    r.ov = 1'b0;
    if (neg) begin
      if (m > (PROD_W'(1) << (VAL_W - 1))) begin
        r.ov = 1'b1;
        r.v  = VMIN;
      end else begin
        r.v = -$signed(m[VAL_W-1:0]);
      end
    end else begin
      if (m > PROD_W'(VMAX)) begin
        r.ov = 1'b1;
        r.v  = VMAX;
      end else begin
        r.v = $signed(m[VAL_W-1:0]);
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pcpe_in_if.sv @@
// pcpe_in_if: input channel of the profile evaluator, load and query words
// depends on pcpe_pkg
interface pcpe_in_if;
  import pcpe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [IDX_W-1:0]        node_index;
  logic signed [VAL_W-1:0] node_depth;
  logic signed [VAL_W-1:0] coeff_value;
  logic signed [VAL_W-1:0] coeff_slope;
  logic signed [VAL_W-1:0] coeff_bend;
  logic signed [VAL_W-1:0] coeff_third;
  logic signed [VAL_W-1:0] node_density;
  logic signed [VAL_W-1:0] query_depth;
  logic [IDX_W-1:0]        hint_segment;

  modport source (
    output valid, action, node_index, node_depth, coeff_value, coeff_slope,
           coeff_bend, coeff_third, node_density, query_depth, hint_segment,
    input  ready
  );

  modport sink (
    input  valid, action, node_index, node_depth, coeff_value, coeff_slope,
           coeff_bend, coeff_third, node_density, query_depth, hint_segment,
    output ready
  );
endinterface

@@ hw/rtl/pcpe_out_if.sv @@
// pcpe_out_if: result channel of the profile evaluator
// depends on pcpe_pkg
interface pcpe_out_if;
  import pcpe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sound_speed;
  logic signed [VAL_W-1:0] speed_gradient;
  logic signed [VAL_W-1:0] speed_curvature;
  logic signed [VAL_W-1:0] density_out;
  logic [IDX_W-1:0]        segment_used;
  logic [STAT_W-1:0]       status;

  modport source (
    output valid, sound_speed, speed_gradient, speed_curvature, density_out,
           segment_used, status,
    input  ready
  );

  modport sink (
    input  valid, sound_speed, speed_gradient, speed_curvature, density_out,
           segment_used, status,
    output ready
  );
endinterface

@@ hw/rtl/pcpe_ram.sv @@
// pcpe_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pcpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/pcpe_qmul.sv @@
// pcpe_qmul: sequential fixed-point multiplier, four 25x25 partial products
// then round, shift and saturate; depends on pcpe_pkg
module pcpe_qmul #(
  parameter int FRACTION_BITS = pcpe_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [pcpe_pkg::OP_W-1:0] a,
  input  logic signed [pcpe_pkg::OP_W-1:0] b,
  output pcpe_pkg::mul_res_t            res
);
  import pcpe_pkg::*;

  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRACTION_BITS - 1);

  logic [2*HALF_W-1:0] am, bm;
  logic [HALF_W-1:0]   ah, bh;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0]   pp_sh, acc, rnd;
  logic [2:0]          step;
  logic                busy, neg, done, ov;
  logic signed [VAL_W-1:0] q;
  sat_t                fin;

  always_comb begin
    ah  = step[0] ? am[2*HALF_W-1:HALF_W] : am[HALF_W-1:0];
    bh  = step[1] ? bm[2*HALF_W-1:HALF_W] : bm[HALF_W-1:0];
    pp  = ah * bh;
    case ({1'b0, step[0]} + {1'b0, step[1]})
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << HALF_W;
      default: pp_sh = PROD_W'(pp) << (2 * HALF_W);
    endcase
    rnd = (acc + RND) >> FRACTION_BITS;
    fin = sat_mag(rnd, neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am   <= (2*HALF_W)'(a[OP_W-1] ? -a : a);
        bm   <= (2*HALF_W)'(b[OP_W-1] ? -b : b);
        neg  <= a[OP_W-1] ^ b[OP_W-1];
        acc  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step != 3'd4) begin
          acc  <= acc + pp_sh;
          step <= step + 3'd1;
        end else begin
          q    <= fin.v;
          ov   <= fin.ov;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

  assign res = '{done: done, neg: neg, ov: ov, q: q, mag: acc};
endmodule

@@ hw/rtl/pcpe_div.sv @@
// pcpe_div: restoring divider, two quotient bits per cycle
// depends on pcpe_pkg
module pcpe_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pcpe_pkg::PROD_W-1:0] num,
  input  logic [pcpe_pkg::OP_W-1:0]   den_in,
  output logic                       busy,
  output logic [pcpe_pkg::PROD_W-1:0] quot
);
  import pcpe_pkg::*;

  localparam int STEPS = 2;
  localparam int ITER  = PROD_W / STEPS;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam int REM_W = OP_W + 1;

  logic [PROD_W-1:0] num_sh, n_nx, q_nx;
  logic [OP_W-1:0]   den;
  logic [REM_W-1:0]  rem, r_nx;
  logic [CNT_W-1:0]  cnt;

  always_comb begin
    r_nx = rem;
    n_nx = num_sh;
    q_nx = quot;
    for (int k = 0; k < STEPS; k++) begin
      r_nx = {r_nx[REM_W-2:0], n_nx[PROD_W-1]};
      n_nx = {n_nx[PROD_W-2:0], 1'b0};
      q_nx = {q_nx[PROD_W-2:0], 1'b0};
      if (r_nx >= {1'b0, den}) begin
        r_nx    = r_nx - {1'b0, den};
        q_nx[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      cnt    <= CNT_W'(ITER);
      rem    <= '0;
      quot   <= '0;
      num_sh <= num;
      den    <= den_in;
    end else if (busy) begin
      rem    <= r_nx;
      num_sh <= n_nx;
      quot   <= q_nx;
      cnt    <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

@@ hw/rtl/piecewise_cubic_profile_eval_core.sv @@
// piecewise_cubic_profile_eval_core: node table in ram, segment search,
// horner evaluation and density interpolation
// depends on pcpe_pkg, pcpe_in_if, pcpe_out_if, pcpe_ram, pcpe_qmul, pcpe_div
//
//   channel   kind          direction  carries
//   req       valid/ready   in         load word or query word
//   rsp       valid/ready   out        one result word per request word
//   cfg       write enable  in         nodes_in_use
//
// a load word writes the ram in its accept cycle; a query takes its segment
// from the hint, a clamp or a binary search of at most log2(nodes)+1 steps;
// ten sequential multiplies on the one qmul unit dominate, division beside them
// one word at a time: req.ready is high only while idle; a finished result
// waits in the output register and the next word can be taken meanwhile
// rsp stalls hold a second finished result in the done state until taken
// synchronous reset clears control state and sets nodes_in_use to 2; the
// table holds no reset, entries are defined once loaded
module piecewise_cubic_profile_eval_core #(
  parameter int MAX_NODES     = pcpe_pkg::MAX_NODES_DEF,
  parameter int FRACTION_BITS = pcpe_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pcpe_pkg::CFG_W-1:0] cfg_wdata,
  pcpe_in_if.sink                    req,
  pcpe_out_if.source                 rsp
);
  import pcpe_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  // node counter width: holds MAX_NODES and the 7-bit register
  localparam int NW = ($clog2(MAX_NODES + 1) > CFG_W) ? $clog2(MAX_NODES + 1) : CFG_W;

  localparam logic signed [VAL_W-1:0] HALF = VAL_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [VAL_W-1:0] SIXTH = (FRACTION_BITS >= 26) ?
    (VAL_W'(SIXTH_MANT) << ((FRACTION_BITS >= 26) ? FRACTION_BITS - 26 : 0)) :
    ((VAL_W'(SIXTH_MANT) + (VAL_W'(1) << ((FRACTION_BITS < 26) ? 25 - FRACTION_BITS : 0)))
      >> ((FRACTION_BITS < 26) ? 26 - FRACTION_BITS : 0));

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_H0, ST_RD_H1, ST_RD_FIRST, ST_RD_LAST, ST_CHK,
    ST_SRCH_ISSUE, ST_SRCH_CMP, ST_RD_SEG, ST_RD_SEG1, ST_OFFS,
    ST_MUL_GO, ST_MUL_WAIT, ST_DENS, ST_DONE
  } state_t;

  // multiply sequence: density product first, then the horner chains
  typedef enum logic [3:0] {
    OP_DENS, OP_SX, OP_SXT, OP_HB, OP_IN1, OP_SPD, OP_HO, OP_GT, OP_GS, OP_CURV
  } op_t;

  state_t state;
  op_t    op;

  logic [CFG_W-1:0]        nodes_cfg;
  logic [NW-1:0]           n, segs, lo, hi, mid;
  logic [NW:0]             mid_sum;
  logic                    idx_ok, bad_hint_c, bad_hint, ov, dneg;
  logic signed [VAL_W-1:0] q_depth, dh0, dh1, dfirst;
  logic [IDX_W-1:0]        hint;
  logic [AW-1:0]           seg, hint_a, raddr;
  row_t                    row0, rd, wrow;
  logic [ROW_W-1:0]        rdata;
  logic                    we;
  logic signed [VAL_W-1:0] o, tmp, speed, grad, curv, dens, add_a;
  logic signed [OP_W-1:0]  span, diff, span_c, diff_c, mul_a, mul_b;
  logic [OP_W-1:0]         span_mag;
  logic [STAT_W-1:0]       status;
  logic                    mul_start, div_start, div_busy;
  logic [PROD_W-1:0]       div_num, quot;
  mul_res_t                mres;
  sat_t                    add_r, off_r, dterm, dsum;

  // config register: the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_cfg <= CFG_W'(CFG_RESET);
    end else if (cfg_we) begin
      nodes_cfg <= cfg_wdata;
    end
  end

  // clamp node count to 2..MAX_NODES
  always_comb begin
    if (NW'(nodes_cfg) < NW'(2)) begin
      n = NW'(2);
    end else if (NW'(nodes_cfg) > NW'(MAX_NODES)) begin
      n = NW'(MAX_NODES);
    end else begin
      n = NW'(nodes_cfg);
    end
    segs       = n - NW'(1);
    bad_hint_c = NW'(req.hint_segment) >= segs;
    idx_ok     = NW'(req.node_index) < NW'(MAX_NODES);
    mid_sum    = {1'b0, lo} + {1'b0, hi};
    mid        = mid_sum[NW:1];
    hint_a     = AW'(hint);
  end

  // table ram: one row per node, all six fields
  assign we   = req.valid && req.ready && (req.action == ACT_LOAD) && idx_ok;
  assign wrow = '{depth: req.node_depth, value: req.coeff_value,
                  slope: req.coeff_slope, bend: req.coeff_bend,
                  third: req.coeff_third, density: req.node_density};
  assign rd   = row_t'(rdata);

  always_comb begin
    unique case (state)
      ST_RD_H0:      raddr = hint_a;
      ST_RD_H1:      raddr = hint_a + AW'(1);
      ST_RD_LAST:    raddr = AW'(n - NW'(1));
      ST_SRCH_ISSUE: raddr = AW'(mid);
      ST_RD_SEG:     raddr = seg;
      ST_RD_SEG1:    raddr = seg + AW'(1);
      default:       raddr = '0;
    endcase
  end

  pcpe_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(AW'(req.node_index)),
    .wdata(wrow),
    .raddr(raddr),
    .rdata(rdata)
  );

  // offset, span and density difference from the two segment rows
  always_comb begin
    off_r  = sat_fit({q_depth[VAL_W-1], q_depth} - {row0.depth[VAL_W-1], row0.depth});
    span_c = {rd.depth[VAL_W-1], rd.depth} - {row0.depth[VAL_W-1], row0.depth};
    diff_c = {rd.density[VAL_W-1], rd.density} - {row0.density[VAL_W-1], row0.density};
  end

  // multiplier operand select
  always_comb begin
    case (op)
      OP_DENS: begin mul_a = diff;                        mul_b = {o[VAL_W-1], o}; end
      OP_SX:   begin mul_a = {1'b0, SIXTH};               mul_b = {o[VAL_W-1], o}; end
      OP_SXT:  begin mul_a = {tmp[VAL_W-1], tmp};         mul_b = {row0.third[VAL_W-1], row0.third}; end
      OP_HB:   begin mul_a = {1'b0, HALF};                mul_b = {row0.bend[VAL_W-1], row0.bend}; end
      OP_IN1,
      OP_SPD,
      OP_GS:   begin mul_a = {o[VAL_W-1], o};             mul_b = {tmp[VAL_W-1], tmp}; end
      OP_HO:   begin mul_a = {1'b0, HALF};                mul_b = {o[VAL_W-1], o}; end
      OP_GT:   begin mul_a = {tmp[VAL_W-1], tmp};         mul_b = {row0.third[VAL_W-1], row0.third}; end
      default: begin mul_a = {o[VAL_W-1], o};             mul_b = {row0.third[VAL_W-1], row0.third}; end
    endcase
    case (op)
      OP_IN1, OP_GS:  add_a = row0.slope;
      OP_SPD:         add_a = row0.value;
      OP_GT, OP_CURV: add_a = row0.bend;
      default:        add_a = tmp;
    endcase
    add_r = sat_add(add_a, mres.q);
    dterm = sat_mag(quot, dneg);
    dsum  = sat_add(row0.density, dterm.v);
  end

  pcpe_qmul #(.FRACTION_BITS(FRACTION_BITS)) u_qmul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .res  (mres)
  );

  pcpe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den_in(span_mag),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_DENS;
      rsp.valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      // the done state reloads the output register itself
      if (rsp.valid && rsp.ready && (state != ST_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.action == ACT_LOAD) begin
              speed  <= '0;
              grad   <= '0;
              curv   <= '0;
              dens   <= '0;
              seg    <= '0;
              status <= idx_ok ? STAT_OK : STAT_LOAD;
              state  <= ST_DONE;
            end else begin
              q_depth  <= req.query_depth;
              hint     <= req.hint_segment;
              bad_hint <= bad_hint_c;
              ov       <= 1'b0;
              state    <= ST_RD_H0;
            end
          end
        end
        ST_RD_H0:    state <= ST_RD_H1;
        ST_RD_H1: begin
          dh0   <= rd.depth;
          state <= ST_RD_FIRST;
        end
        ST_RD_FIRST: begin
          dh1   <= rd.depth;
          state <= ST_RD_LAST;
        end
        ST_RD_LAST: begin
          dfirst <= rd.depth;
          state  <= ST_CHK;
        end
        ST_CHK: begin
          // rd holds the last node depth here
          if (!bad_hint && (q_depth >= dh0) && (q_depth <= dh1)) begin
            seg   <= hint_a;
            state <= ST_RD_SEG;
          end else if (q_depth < dfirst) begin
            seg   <= '0;
            state <= ST_RD_SEG;
          end else if (q_depth > rd.depth) begin
            seg   <= AW'(segs - NW'(1));
            state <= ST_RD_SEG;
          end else begin
            lo    <= '0;
            hi    <= n;
            state <= ST_SRCH_ISSUE;
          end
        end
        ST_SRCH_ISSUE: begin
          if (lo < hi) begin
            state <= ST_SRCH_CMP;
          end else begin
            // first node not shallower than the depth, less one, clamped
            if (lo == '0) begin
              seg <= '0;
            end else if ((lo - NW'(1)) < (segs - NW'(1))) begin
              seg <= AW'(lo - NW'(1));
            end else begin
              seg <= AW'(segs - NW'(1));
            end
            state <= ST_RD_SEG;
          end
        end
        ST_SRCH_CMP: begin
          if (rd.depth < q_depth) begin
            lo <= mid + NW'(1);
          end else begin
            hi <= mid;
          end
          state <= ST_SRCH_ISSUE;
        end
        ST_RD_SEG:   state <= ST_RD_SEG1;
        ST_RD_SEG1: begin
          row0  <= rd;
          state <= ST_OFFS;
        end
        ST_OFFS: begin
          o        <= off_r.v;
          ov       <= off_r.ov;
          span     <= span_c;
          diff     <= diff_c;
          span_mag <= span_c[OP_W-1] ? OP_W'(-span_c) : OP_W'(span_c);
          op       <= OP_DENS;
          state    <= ST_MUL_GO;
        end
        ST_MUL_GO: begin
          mul_start <= 1'b1;
          state     <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mres.done) begin
            case (op)
              OP_DENS: begin
                if (span != '0) begin
                  div_num   <= mres.mag + PROD_W'(span_mag >> 1);
                  dneg      <= mres.neg ^ span[OP_W-1];
                  div_start <= 1'b1;
                end
              end
              OP_SX, OP_SXT: begin
                tmp <= mres.q;
                ov  <= ov | mres.ov;
              end
              OP_HB, OP_IN1: begin
                tmp <= add_r.v;
                ov  <= ov | mres.ov | add_r.ov;
              end
              OP_SPD: begin
                speed <= add_r.v;
                ov    <= ov | mres.ov | add_r.ov;
              end
              OP_HO:   tmp  <= mres.q;
              OP_GT:   tmp  <= add_r.v;
              OP_GS:   grad <= add_r.v;
              default: curv <= add_r.v;
            endcase
            if (op == OP_CURV) begin
              state <= ST_DENS;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= ST_MUL_GO;
            end
          end
        end
        ST_DENS: begin
          if (span == '0 || !div_busy) begin
            dens <= (span == '0) ? row0.density : dsum.v;
            if (bad_hint) begin
              status <= STAT_HINT;
            end else if (ov || (speed <= 0)) begin
              status <= STAT_SPEED;
            end else begin
              status <= STAT_OK;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.sound_speed     <= speed;
            rsp.speed_gradient  <= grad;
            rsp.speed_curvature <= curv;
            rsp.density_out     <= dens;
            rsp.segment_used    <= IDX_W'(seg);
            rsp.status          <= status;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // no division may still be running when a new word can be taken
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_busy)
    else $error("divider busy while idle");

  // table is written only at the accept of a load word
  a_we_idle: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == ST_IDLE) && req.valid)
    else $error("table write outside load accept");

  // search compares only with a nonempty interval
  a_srch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP) |-> (lo < hi))
    else $error("search interval empty at compare");

  // a load beyond the table returns zero fields
  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_LOAD) |->
      (rsp.segment_used == '0) && (rsp.sound_speed == '0))
    else $error("load result carries data");
`endif
endmodule

@@ bench/piecewise_cubic_profile_eval_core_tb.sv @@
// piecewise_cubic_profile_eval_core_tb: self-checking bench for the profile evaluator,
// with loads, queries, node-count changes and random stalls on both channels
// depends on pcpe_pkg, pcpe_in_if, pcpe_out_if and the core with its submodules
module piecewise_cubic_profile_eval_core_tb;
  import pcpe_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int NODES     = MAX_NODES_DEF;
  localparam int SETTLE    = 300;
  localparam int MAX_SHOWN = 10;

  typedef logic signed [VAL_W-1:0] q_t;

  // one request word as the bench builds it
  typedef struct {
    logic             action;
    logic [IDX_W-1:0] idx;
    q_t               depth, value, slope, bend, third, density, qdepth;
    logic [IDX_W-1:0] hint;
  } req_word_t;

  // one expected result word
  typedef struct {
    q_t                speed, grad, curv, dens;
    logic [IDX_W-1:0]  seg;
    logic [STAT_W-1:0] st;
  } profile_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pcpe_in_if  req ();
  pcpe_out_if rsp ();

  piecewise_cubic_profile_eval_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // bench copy of the node table and the node-count register
  q_t               depth_tab [NODES];
  q_t               value_tab [NODES];
  q_t               slope_tab [NODES];
  q_t               bend_tab [NODES];
  q_t               third_tab [NODES];
  q_t               dens_tab [NODES];
  logic [CFG_W-1:0] node_cfg;

  profile_result_t pending_results[$];
  int              fail_count;
  int              src_idle_pct;
  int              snk_idle_pct;
  int              hold_left;
  logic [IDX_W-1:0] last_seg;

  localparam q_t HALF_Q  = q_t'(64'd1 << (FRAC - 1));
  localparam q_t SIXTH_Q = q_t'(64'(SIXTH_MANT) << (FRAC - 26));

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point arithmetic of the evaluator, bit exact
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // clamp a wide sum into 48 bits and note the overflow
  function automatic q_t clamp48(input longint v, inout bit ov);
    if (v > longint'(VMAX)) begin
      ov = 1'b1;
      return VMAX;
    end
    if (v < longint'(VMIN)) begin
      ov = 1'b1;
      return VMIN;
    end
    return q_t'(v);
  endfunction

  // magnitude plus sign back to a saturated 48-bit value
  function automatic q_t from_mag(input logic [127:0] m, input bit neg, inout bit ov);
    if (neg) begin
      if (m > (128'd1 << (VAL_W - 1))) begin
        ov = 1'b1;
        return VMIN;
      end
      return q_t'(-longint'(m[63:0]));
    end
    if (m > ((128'd1 << (VAL_W - 1)) - 1)) begin
      ov = 1'b1;
      return VMAX;
    end
    return q_t'(m[63:0]);
  endfunction

  // exact product, rounded half away from zero at the fraction point
  function automatic q_t fx_mul(input q_t a, input q_t b, inout bit ov);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p + (128'd1 << (FRAC - 1));
    p = p >> FRAC;
    return from_mag(p, (a < 0) != (b < 0), ov);
  endfunction

  function automatic int seg_count();
    int n;
    n = node_cfg;
    if (n < 2) n = 2;
    if (n > NODES) n = NODES;
    return n;
  endfunction

  // hinted segment first, then clamp below/above, then binary search
  function automatic int find_segment(input q_t d, input int hint, output bit bad_hint);
    int n, segs, lo, hi, mid;
    n = seg_count();
    segs = n - 1;
    lo = 0;
    hi = n;
    bad_hint = hint >= segs;
    if (!bad_hint && d >= depth_tab[hint] && d <= depth_tab[hint+1]) return hint;
    if (d < depth_tab[0]) return 0;
    if (d > depth_tab[n-1]) return segs - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (depth_tab[mid] < d) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return 0;
    return (lo - 1 < segs - 1) ? lo - 1 : segs - 1;
  endfunction

  // expected result for one accepted word; loads also update the table copy
  function automatic profile_result_t eval_profile(input req_word_t w);
    profile_result_t r;
    bit               ov, junk, bad_hint, neg;
    int               seg;
    q_t               o, v, s, b, t, inner, prod;
    longint           span, diff;
    logic [127:0]     p;
    r = '{default: '0};
    ov = 1'b0;
    junk = 1'b0;
    if (w.action == ACT_LOAD) begin
      depth_tab[w.idx] = w.depth;
      value_tab[w.idx] = w.value;
      slope_tab[w.idx] = w.slope;
      bend_tab[w.idx]  = w.bend;
      third_tab[w.idx] = w.third;
      dens_tab[w.idx]  = w.density;
      r.st = STAT_OK;
      return r;
    end
    seg = find_segment(w.qdepth, w.hint, bad_hint);
    v = value_tab[seg];
    s = slope_tab[seg];
    b = bend_tab[seg];
    t = third_tab[seg];
    o = clamp48(longint'(w.qdepth) - longint'(depth_tab[seg]), ov);

    // sound speed, every saturation counts; one step per statement
    prod = fx_mul(SIXTH_Q, o, ov);
    inner = fx_mul(prod, t, ov);
    prod = fx_mul(HALF_Q, b, ov);
    inner = clamp48(longint'(prod) + longint'(inner), ov);
    prod = fx_mul(o, inner, ov);
    inner = clamp48(longint'(s) + longint'(prod), ov);
    prod = fx_mul(o, inner, ov);
    r.speed = clamp48(longint'(v) + longint'(prod), ov);

    // gradient and curvature saturate silently
    r.grad = fx_mul(fx_mul(HALF_Q, o, junk), t, junk);
    r.grad = clamp48(longint'(b) + longint'(r.grad), junk);
    r.grad = clamp48(longint'(s) + longint'(fx_mul(o, r.grad, junk)), junk);
    r.curv = clamp48(longint'(b) + longint'(fx_mul(o, t, junk)), junk);

    // density: one rounded division of the exact product, zero span keeps d0
    r.dens = dens_tab[seg];
    span = longint'(depth_tab[seg+1]) - longint'(depth_tab[seg]);
    if (span != 0) begin
      diff = longint'(dens_tab[seg+1]) - longint'(dens_tab[seg]);
      neg = ((diff < 0) != (o < 0)) != (span < 0);
      p = {64'd0, mag64(diff)} * {64'd0, mag64(o)} + (mag64(span) >> 1);
      p = p / {64'd0, mag64(span)};
      r.dens = clamp48(longint'(r.dens) + longint'(from_mag(p, neg, junk)), junk);
    end

    r.seg = IDX_W'(seg);
    if (bad_hint) r.st = STAT_HINT;
    else if (ov || r.speed <= 0) r.st = STAT_SPEED;
    else r.st = STAT_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready with random stalls or a counted hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // compare every taken result word with the oldest expectation
  always @(posedge clk) begin
    profile_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < MAX_SHOWN) $display("unexpected result word at %0t", $realtime);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (rsp.sound_speed !== e.speed || rsp.speed_gradient !== e.grad ||
            rsp.speed_curvature !== e.curv || rsp.density_out !== e.dens ||
            rsp.segment_used !== e.seg || rsp.status !== e.st) begin
          if (fail_count < MAX_SHOWN) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp speed %h grad %h curv %h dens %h seg %0d st %0d",
                     e.speed, e.grad, e.curv, e.dens, e.seg, e.st);
            $display("  got speed %h grad %h curv %h dens %h seg %0d st %0d",
                     rsp.sound_speed, rsp.speed_gradient, rsp.speed_curvature,
                     rsp.density_out, rsp.segment_used, rsp.status);
          end
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  // offer one word after a random gap, predict it at the accepting edge
  task automatic send_word(input req_word_t w);
    profile_result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= w.action;
    req.node_index   <= w.idx;
    req.node_depth   <= w.depth;
    req.coeff_value  <= w.value;
    req.coeff_slope  <= w.slope;
    req.coeff_bend   <= w.bend;
    req.coeff_third  <= w.third;
    req.node_density <= w.density;
    req.query_depth  <= w.qdepth;
    req.hint_segment <= w.hint;
    do @(posedge clk); while (!req.ready);
    r = eval_profile(w);
    if (w.action == ACT_QUERY) last_seg = r.seg;
    pending_results.insert(pending_results.size(), r);
  endtask

  // sender stops until every result is back, plus the block's own latency
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    node_cfg = n;
    cfg_we <= 1'b0;
  endtask

  function automatic q_t rand_full();
    return q_t'({$urandom, $urandom});
  endfunction

  // signed value with magnitude below 2^bits
  function automatic q_t rand_scaled(input int bits);
    return q_t'(longint'({$urandom, $urandom}) >>> (64 - bits));
  endfunction

  function automatic req_word_t load_word(input int idx, input q_t depth,
                                          input q_t value, input q_t slope,
                                          input q_t bend, input q_t third,
                                          input q_t density);
    req_word_t w;
    w = '{default: '0};
    w.action = ACT_LOAD;
    w.idx = IDX_W'(idx);
    w.depth = depth;
    w.value = value;
    w.slope = slope;
    w.bend = bend;
    w.third = third;
    w.density = density;
    w.qdepth = rand_full();
    w.hint = IDX_W'($urandom);
    return w;
  endfunction

  function automatic req_word_t query_word(input q_t d, input int hint);
    req_word_t w;
    w = load_word($urandom_range(63), rand_full(), rand_full(), rand_full(),
                  rand_full(), rand_full(), rand_full());
    w.action = ACT_QUERY;
    w.qdepth = d;
    w.hint = IDX_W'(hint);
    return w;
  endfunction

  // random coefficients: mostly a plausible profile, sometimes anything
  function automatic req_word_t random_load(input int idx, input q_t depth);
    if ($urandom_range(7) == 0)
      return load_word(idx, depth, rand_full(), rand_full(), rand_full(),
                       rand_full(), rand_full());
    return load_word(idx, depth, q_t'(64'd1500 << FRAC) + rand_scaled(38),
                     rand_scaled(32), rand_scaled(26), rand_scaled(20),
                     q_t'(64'd1025 << FRAC) + rand_scaled(34));
  endfunction

  // rewrite the first n nodes with ascending depths, a few spans zero
  task automatic load_sorted_table(input int n);
    q_t d;
    d = rand_scaled(44);
    for (int i = 0; i < n; i++) begin
      send_word(random_load(i, d));
      if ($urandom_range(15) != 0)
        d = d + q_t'(64'($urandom_range(1, 1 << 20)) << $urandom_range(0, 18));
    end
  endtask

  // depth mostly inside or just around the table, sometimes anywhere
  function automatic q_t random_depth();
    logic [63:0] range;
    int          n;
    n = seg_count();
    if ($urandom_range(7) == 0 || depth_tab[n-1] < depth_tab[0]) return rand_full();
    range = 64'(longint'(depth_tab[n-1]) - longint'(depth_tab[0])) + (64'd1 << 37);
    return q_t'(longint'(depth_tab[0]) - (64'd1 << 36) + ({$urandom, $urandom} % range));
  endfunction

  function automatic int random_hint();
    case ($urandom_range(3))
      0, 1: return last_seg;
      2:    return $urandom_range(seg_count() - 2);
      default: return $urandom_range(63);
    endcase
  endfunction

  // mixed traffic: mostly queries, some loads that keep or break the order
  task automatic random_traffic(input int count);
    int idx;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 15) begin
        idx = $urandom_range(63);
        send_word(random_load(idx, ($urandom_range(6) == 0) ? rand_full() : depth_tab[idx]));
      end else begin
        send_word(query_word(random_depth(), random_hint()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // small hand-built table: clamping, hint hit and miss, bad hints,
  // zero span, saturating and negative speed, extreme load words
  task automatic test_directed();
    write_node_count(5);
    send_word(load_word(0, q_t'(-64'd100 << FRAC), VMAX, VMAX, VMAX, VMAX, VMIN));
    send_word(load_word(1, 0, q_t'(64'd1500 << FRAC), q_t'(64'd1 << 30),
                        q_t'(-64'd1 << 24), q_t'(64'd1 << 16), q_t'(64'd1025 << FRAC)));
    send_word(load_word(2, q_t'(64'd50 << FRAC), q_t'(64'd1510 << FRAC), 0, 0, 0,
                        q_t'(64'd1030 << FRAC)));
    send_word(load_word(3, q_t'(64'd50 << FRAC), q_t'(-64'd20 << FRAC),
                        q_t'(-64'd1 << FRAC), 0, 0, q_t'(64'd1040 << FRAC)));
    send_word(load_word(4, q_t'(64'd200 << FRAC), q_t'(64'd1490 << FRAC), 0, 0, 0,
                        q_t'(64'd1050 << FRAC)));
    send_word(load_word(5, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX));
    send_word(load_word(63, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN));
    send_word(query_word(q_t'(-64'd200 << FRAC), 0));
    send_word(query_word(VMIN, 3));
    send_word(query_word(VMAX, 1));
    send_word(query_word(q_t'(64'd25 << FRAC), 1));
    send_word(query_word(q_t'(64'd25 << FRAC), 0));
    send_word(query_word(q_t'(64'd50 << FRAC), 2));
    send_word(query_word(q_t'(64'd25 << FRAC), 4));
    send_word(query_word(q_t'(64'd25 << FRAC), 63));
    send_word(query_word(q_t'(-64'd100 << FRAC), 0));
    send_word(query_word(q_t'(64'd120 << FRAC), 3));
    send_word(query_word(q_t'(-64'd50 << FRAC), 0));
    send_word(query_word(q_t'(64'd200 << FRAC), 3));
    send_word(query_word(q_t'(64'd7 << FRAC) + 1, 1));
    drain();
  endtask

  // one idling mix over several node counts, extremes included
  task automatic test_random_phase(input int src_pct, input int snk_pct,
                                   input logic [CFG_W-1:0] n_first,
                                   input logic [CFG_W-1:0] n_second);
    logic [CFG_W-1:0] n_list [3];
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    n_list[0] = n_first;
    n_list[1] = n_second;
    n_list[2] = CFG_W'($urandom_range(2, NODES));
    foreach (n_list[i]) begin
      write_node_count(n_list[i]);
      load_sorted_table(seg_count());
      random_traffic(160);
    end
  endtask

  // long counted hold-off on results while words keep coming, then a full stop
  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_left = 600;
    random_traffic(8);
    drain();
    random_traffic(20);
    drain();
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req.valid    <= 1'b0;
    req.action   <= ACT_LOAD;
    req.node_index   <= '0;
    req.node_depth   <= '0;
    req.coeff_value  <= '0;
    req.coeff_slope  <= '0;
    req.coeff_bend   <= '0;
    req.coeff_third  <= '0;
    req.node_density <= '0;
    req.query_depth  <= '0;
    req.hint_segment <= '0;
    fail_count   = 0;
    src_idle_pct = 23;
    snk_idle_pct = 52;
    hold_left    = 0;
    last_seg     = '0;
    node_cfg     = CFG_W'(CFG_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    // all 64 nodes defined before any larger node count is used
    write_node_count(CFG_W'(NODES));
    load_sorted_table(NODES);
    test_random_phase(23, 52, CFG_W'(NODES), CFG_W'(2));
    test_random_phase(52, 23, CFG_W'(0), CFG_W'(127));
    test_backpressure();
    test_random_phase(0, 0, CFG_W'($urandom_range(2, NODES)), CFG_W'(NODES));
    drain();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pcpe_pkg.sv
hw/rtl/pcpe_in_if.sv
hw/rtl/pcpe_out_if.sv
hw/rtl/pcpe_ram.sv
hw/rtl/pcpe_qmul.sv
hw/rtl/pcpe_div.sv
hw/rtl/piecewise_cubic_profile_eval_core.sv
bench/piecewise_cubic_profile_eval_core_tb.sv
